/* src/rhd_pkg.sv */
package rhd_pkg;

   // Bytes per finger record and the touch payload header.
   localparam int unsigned FingerBytes = 7;
   localparam logic [7:0]  TouchHeader = 8'h32;
   localparam logic [7:0]  HeaderLen   = 8'd4;
   localparam logic [7:0]  PosSat      = 8'hff;

   typedef enum logic [1:0] {
      CSR_KEYS_ID     = 2'd0,
      CSR_TOUCH_ID    = 2'd1,
      CSR_SKIP_PREFIX = 2'd2,
      CSR_MOUSE_MASK  = 2'd3
   } csr_index_type;

   typedef enum logic {
      EVENT_KEY   = 1'b0,
      EVENT_TOUCH = 1'b1
   } event_kind_type;

   typedef struct packed {
      event_kind_type     event_kind;
      logic [15:0]        key_bits;
      logic               mouse_button;
      logic               slot_index;
      logic               finger_down;
      logic [12:0]        pos_x;
      logic signed [13:0] pos_y_inverted;
      logic [7:0]         contact_major;
      logic [7:0]         contact_minor;
      logic [7:0]         contact_pressure;
      logic [2:0]         contact_angle;
   } result_type;

endpackage

/* src/remote_hid_report_decoder_core.sv */
// Remote HID report decoder. Report bytes enter on the req stream one word
// per cycle, id first, tlast on the final byte. A report whose id matches the
// keys id gives one key word result; one whose id matches the touch id and
// carries a well-formed touch payload gives MAX_FINGERS slot results, after
// the key result when both ids match. Results leave on the rsp stream one word
// per cycle while rsp_tready is high, tlast on the last result of a report.
// A report's results are built in the cycle after its last byte from the
// byte-state registers and loaded into a result bundle of MAX_FINGERS+1
// entries; the input stalls only while a finished report waits for the bundle
// to drain. Configuration is written through csr_wen/csr_index/csr_wdata; the
// user must do so only while the stream is idle, as the block does not check it.
module remote_hid_report_decoder_core
   import rhd_pkg::*;
#(
   parameter int unsigned MAX_FINGERS = 2
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // report_byte [7:0]
   input  logic        req_tlast,   // end_of_report

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // key_bits [15:0], mouse_button [16], slot_index [17], finger_down [18],
   // pos_x [31:19], pos_y_inverted [45:32], contact_major [53:46],
   // contact_minor [61:54], contact_pressure [69:62], contact_angle [72:70]
   output logic [79:0] rsp_tdata,
   output logic        rsp_tuser,   // event_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam int unsigned StoreLen  = MAX_FINGERS * FingerBytes;
   localparam int unsigned StoreIdxW = $clog2(StoreLen);
   localparam int unsigned NumRes    = MAX_FINGERS + 1;
   localparam int unsigned ResIdxW   = $clog2(NumRes);
   localparam int unsigned ResCntW   = $clog2(NumRes + 1);

   // configuration
   logic [7:0]  keys_id_ff;
   logic [7:0]  touch_id_ff;
   logic        skip_ff;
   logic [15:0] mouse_mask_ff;

   // byte state
   logic [7:0]  pos_ff;
   logic [7:0]  report_id_ff;
   logic [15:0] key_word_ff;
   logic [7:0]  header_ff;
   logic [7:0]  end_count_ff;
   logic        done_ff;
   logic        done_in;
   logic [7:0]  store_ff [StoreLen];

   // result bundle
   result_type         bundle_ff [NumRes];
   logic [ResIdxW-1:0] head_ff;
   logic [ResCntW-1:0] left_ff;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 bundle_load;
   logic [7:0]           skip_len;
   logic [7:0]           data_pos;
   logic [7:0]           touch_pos;
   logic [7:0]           pos_next;
   logic                 in_body;
   logic                 store_we;
   logic [StoreIdxW-1:0] store_idx;

   logic [7:0]           size;
   logic [7:0]           tsize;
   logic                 len_match;
   logic [ResCntW-1:0]   finger_count;
   logic                 key_hit;
   logic                 touch_hit;
   result_type           key_res;
   result_type           slot_res [NumRes];
   result_type           build [NumRes];
   logic [ResCntW-1:0]   load_count;
   result_type           cur;

   // ---------------------------------------------------------------- handshake
   assign rsp_tvalid  = (left_ff != '0);
   assign rsp_fire    = rsp_tvalid && rsp_tready;
   // load the bundle once the previous report's results are gone or leaving
   assign bundle_load = done_ff &&
                        ((left_ff == '0) || ((left_ff == ResCntW'(1)) && rsp_tready));
   // hold input while a finished report still waits for the bundle
   assign req_tready  = !done_ff || bundle_load;
   assign req_fire    = req_tvalid && req_tready;

   // ---------------------------------------------------------------- byte path
   always_comb begin
      skip_len  = skip_ff ? 8'd2 : 8'd0;
      data_pos  = pos_ff - 8'd1;
      touch_pos = data_pos - skip_len;
      pos_next  = (pos_ff != PosSat) ? pos_ff + 8'd1 : pos_ff;
      in_body   = (pos_ff != 8'd0) && (pos_ff != PosSat);
      store_we  = req_fire && in_body && (data_pos >= skip_len) &&
                  (touch_pos >= HeaderLen) &&
                  ((touch_pos - HeaderLen) < 8'(StoreLen));
      store_idx = StoreIdxW'(touch_pos - HeaderLen);
      done_in   = req_fire ? req_tlast : (done_ff && !bundle_load);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_id_ff    <= 8'd251;
         touch_id_ff   <= 8'd252;
         skip_ff       <= 1'b0;
         mouse_mask_ff <= 16'h0800;
         pos_ff        <= 8'd0;
         report_id_ff  <= 8'd0;
         key_word_ff   <= 16'd0;
         header_ff     <= 8'd0;
         done_ff       <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index_type'(csr_index))
               CSR_KEYS_ID:     keys_id_ff    <= csr_wdata[7:0];
               CSR_TOUCH_ID:    touch_id_ff   <= csr_wdata[7:0];
               CSR_SKIP_PREFIX: skip_ff       <= csr_wdata[0];
               CSR_MOUSE_MASK:  mouse_mask_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_fire) begin
            if (pos_ff == 8'd0) begin
               report_id_ff <= req_tdata;
               key_word_ff  <= 16'd0;
            end else if (in_body) begin
               if (data_pos == 8'd0) key_word_ff[15:8] <= req_tdata;
               if (data_pos == 8'd1) key_word_ff[7:0]  <= req_tdata;
               if ((data_pos >= skip_len) && (touch_pos == 8'd0)) header_ff <= req_tdata;
            end
            // restart the count on the last byte
            pos_ff <= req_tlast ? 8'd0 : pos_next;
         end
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) end_count_ff <= pos_next;
      if (store_we) store_ff[store_idx] <= req_tdata;
   end

   // ---------------------------------------------------------------- decode
   always_comb begin
      size      = end_count_ff - 8'd1;
      tsize     = size - skip_len - HeaderLen;
      len_match = 1'b0;
      finger_count = '0;
      // finger payload must be a whole number of records, at most MAX_FINGERS
      for (int k = 0; k <= int'(MAX_FINGERS); k++) begin
         if (tsize == 8'(k * FingerBytes)) begin
            len_match    = 1'b1;
            finger_count = ResCntW'(k);
         end
      end
      key_hit   = (report_id_ff == keys_id_ff);
      touch_hit = (report_id_ff == touch_id_ff) && (end_count_ff != PosSat) &&
                  (size >= skip_len + HeaderLen) && (header_ff == TouchHeader) &&
                  len_match;

      key_res              = '0;
      key_res.event_kind   = EVENT_KEY;
      key_res.key_bits     = key_word_ff;
      key_res.mouse_button = |(key_word_ff & mouse_mask_ff);
   end

   for (genvar s = 0; s < MAX_FINGERS; s++) begin : g_slot
      logic [FingerBytes-1:0][7:0] fbytes;
      for (genvar j = 0; j < FingerBytes; j++) begin : g_byte
         assign fbytes[j] = store_ff[s * FingerBytes + j];
      end
      rhd_slot_decode u_slot (
         .slot_used    (ResCntW'(s) < finger_count),
         .slot_num     (1'(s)),
         .finger_bytes (fbytes),
         .slot_result  (slot_res[s])
      );
   end
   assign slot_res[MAX_FINGERS] = '0;

   // pack the key result first, then the slots
   always_comb begin
      build[0] = key_hit ? key_res : slot_res[0];
      for (int e = 1; e < int'(NumRes); e++) begin
         build[e] = key_hit ? slot_res[e-1] : slot_res[e];
      end
      load_count = ResCntW'(key_hit) + (touch_hit ? ResCntW'(MAX_FINGERS) : '0);
   end

   // ---------------------------------------------------------------- bundle
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         head_ff <= '0;
      end else if (bundle_load) begin
         left_ff <= load_count;
         head_ff <= '0;
      end else if (rsp_fire) begin
         left_ff <= left_ff - ResCntW'(1);
         head_ff <= head_ff + ResIdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_load) begin
         for (int e = 0; e < int'(NumRes); e++) bundle_ff[e] <= build[e];
      end
   end

   assign cur       = bundle_ff[head_ff];
   assign rsp_tdata = {7'd0, cur.contact_angle, cur.contact_pressure, cur.contact_minor,
                       cur.contact_major, cur.pos_y_inverted, cur.pos_x, cur.finger_down,
                       cur.slot_index, cur.mouse_button, cur.key_bits};
   assign rsp_tuser = cur.event_kind;
   assign rsp_tlast = (left_ff == ResCntW'(1));

   // ---------------------------------------------------------------- checks
   a_touch_no_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[16:0] == 17'd0))
      else $error("touch result carries key bits");

   a_up_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[18]) |-> (rsp_tdata[72:19] == 54'd0))
      else $error("released result carries contact data");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      left_ff <= ResCntW'(NumRes))
      else $error("bundle count out of range");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast && !bundle_load) |=> !rsp_tvalid)
      else $error("result after last of run");

   a_state_held: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !bundle_load) |=> ($stable(report_id_ff) && $stable(key_word_ff)))
      else $error("report state changed before decode");

endmodule

/* src/rhd_slot_decode.sv */
module rhd_slot_decode
   import rhd_pkg::*;
(
   input  logic                        slot_used,
   input  logic                        slot_num,
   input  logic [FingerBytes-1:0][7:0] finger_bytes,
   output result_type                  slot_result
);

   logic [11:0] raw_x;
   logic [11:0] raw_y;
   logic [12:0] wrap_x;
   logic [12:0] wrap_y;
   logic        down;

   always_comb begin
      raw_x  = {finger_bytes[1][3:0], finger_bytes[0]};
      raw_y  = {finger_bytes[2], finger_bytes[1][7:4]};
      // below 0x800 wraps up by 0x1000: bit 12 is the inverse of bit 11
      wrap_x = {~raw_x[11], raw_x};
      wrap_y = {~raw_y[11], raw_y};
      down   = slot_used && (finger_bytes[4] != 8'd0);

      slot_result            = '0;
      slot_result.event_kind = EVENT_TOUCH;
      slot_result.slot_index = slot_num;
      if (down) begin
         slot_result.finger_down      = 1'b1;
         slot_result.pos_x            = wrap_x;
         slot_result.pos_y_inverted   = 14'(14'd0 - {1'b0, wrap_y});
         slot_result.contact_major    = finger_bytes[3];
         slot_result.contact_minor    = finger_bytes[5];
         slot_result.contact_pressure = finger_bytes[4];
         slot_result.contact_angle    = finger_bytes[6][7:5];
      end
   end

endmodule

/* sim/remote_hid_report_decoder_core_tb.sv */
`timescale 1ns / 1ps

module remote_hid_report_decoder_core_tb;
   import rhd_pkg::*;

   localparam int unsigned MaxFingers   = 2;
   localparam int unsigned StoreLen     = MaxFingers * FingerBytes;
   // Cycles to let a dropped report finish inside the block before a CSR write.
   localparam int unsigned DrainCycles  = 8;
   localparam int unsigned PhaseCount   = 6;
   localparam int unsigned PhaseWords   = 43;
   localparam int unsigned DirectedRows = 25;
   localparam int unsigned ReportLimit  = 10;

   // One expected or observed rsp word: the packed result plus its tlast.
   typedef struct packed {
      result_type body;
      logic       last_of_run;
   } report_event_type;

   // Receiver back-pressure patterns.
   typedef enum int unsigned {
      SINK_OPEN  = 0,
      SINK_COIN  = 1,
      SINK_COMB  = 2,
      SINK_CHOKE = 3
   } sink_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_wen    = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // report_byte [7:0]
   logic        req_tlast  = 1'b0; // end_of_report
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // key_bits [15:0], mouse_button [16], slot_index [17], finger_down [18],
   // pos_x [31:19], pos_y_inverted [45:32], contact_major [53:46],
   // contact_minor [61:54], contact_pressure [69:62], contact_angle [72:70]
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;         // event_kind
   logic        rsp_tlast;         // last_of_run

   // Decoder shadow: configuration and per-report byte state.
   logic [7:0]  cfg_keys_id  = 8'd251;
   logic [7:0]  cfg_touch_id = 8'd252;
   logic        cfg_skip     = 1'b0;
   logic [15:0] cfg_mask     = 16'h0800;
   logic [7:0]  dec_pos      = '0;
   logic [7:0]  dec_id       = '0;
   logic [15:0] dec_key      = '0;
   logic [7:0]  dec_header   = '0;
   logic [7:0]  dec_store [StoreLen];

   report_event_type pending_events [$];
   logic [7:0]       report_bytes [$];
   int unsigned      fail_count  = 0;
   int unsigned      burst_left  = 5;
   bit               valid_held  = 1'b0;
   sink_mode_type    ready_mode  = SINK_OPEN;
   int unsigned      ready_tick  = 0;

   // Directed words: {byte, end of report, typed golden, click, key word}.
   // Rows with the typed flag carry their key result inline; the rest go
   // through the shadow decoder.
   logic [26:0] directed_rows [DirectedRows] = '{
      // id-only keys report: zero key word, no click
      {8'hfb, 1'b1, 1'b1, 1'b0, 16'h0000},
      // full key word, every bit set
      {8'hfb, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'hff, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'hff, 1'b1, 1'b1, 1'b1, 16'hffff},
      // second key byte missing, reads as zero
      {8'hfb, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h08, 1'b1, 1'b1, 1'b1, 16'h0800},
      // touch with header only: both slots released
      {8'hfc, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h32, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h00, 1'b1, 1'b0, 1'b0, 16'h0000},
      // touch with one finger at X = Y = 0 (both wrap), max major and angle
      {8'hfc, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h32, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h11, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h22, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h33, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'hff, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h01, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h80, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'he0, 1'b1, 1'b0, 1'b0, 16'h0000},
      // short touch payload: dropped, nothing comes out
      {8'hfc, 1'b0, 1'b0, 1'b0, 16'h0000},
      {8'h32, 1'b1, 1'b0, 1'b0, 16'h0000}
   };

   remote_hid_report_decoder_core #(
      .MAX_FINGERS(MaxFingers)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advance the shadow decoder by one accepted byte and, on the last byte,
   // queue the key result and the touch-slot results the report yields.
   task automatic decode_report_byte(input logic [7:0] b, input logic eor, input bit emit);
      int unsigned      pos;
      int unsigned      skip;
      int unsigned      d;
      int unsigned      t;
      int unsigned      tsize;
      int unsigned      nf;
      int unsigned      fi;
      int unsigned      base;
      int unsigned      x;
      int unsigned      y;
      report_event_type ev;
      report_event_type batch [$];
      pos  = dec_pos;
      skip = cfg_skip ? 2 : 0;
      if (pos == 0) begin
         dec_id  = b;
         dec_key = '0;
      end else if (pos < PosSat) begin
         d = pos - 1;
         if (d == 0) dec_key[15:8] = b;
         else if (d == 1) dec_key[7:0] = b;
         if (d >= skip) begin
            t = d - skip;
            if (t == 0) dec_header = b;
            else if (t >= HeaderLen && t - HeaderLen < StoreLen) dec_store[t - HeaderLen] = b;
         end
      end
      // Saturate the count: a report this long has no usable length.
      if (pos < PosSat) pos++;
      dec_pos = 8'(pos);
      if (eor) begin
         dec_pos = '0;
         if (dec_id == cfg_keys_id) begin
            ev = '0;
            ev.body.event_kind   = EVENT_KEY;
            ev.body.key_bits     = dec_key;
            ev.body.mouse_button = |(dec_key & cfg_mask);
            batch.push_back(ev);
         end
         if (dec_id == cfg_touch_id && pos < PosSat && pos - 1 >= skip + HeaderLen) begin
            tsize = pos - 1 - skip - HeaderLen;
            nf    = tsize / FingerBytes;
            if (dec_header == TouchHeader && tsize % FingerBytes == 0 && nf <= MaxFingers) begin
               for (fi = 0; fi < MaxFingers; fi++) begin
                  ev = '0;
                  ev.body.event_kind = EVENT_TOUCH;
                  ev.body.slot_index = fi[0];
                  base = fi * FingerBytes;
                  // Unused slots and zero-pressure fingers stay released.
                  if (fi < nf && dec_store[base + 4] != 8'h00) begin
                     x = {dec_store[base + 1][3:0], dec_store[base]};
                     y = {dec_store[base + 2], dec_store[base + 1][7:4]};
                     if (x < 'h800) x += 'h1000;
                     if (y < 'h800) y += 'h1000;
                     ev.body.finger_down      = 1'b1;
                     ev.body.pos_x            = 13'(x);
                     ev.body.pos_y_inverted   = 14'(0 - y);
                     ev.body.contact_major    = dec_store[base + 3];
                     ev.body.contact_minor    = dec_store[base + 5];
                     ev.body.contact_pressure = dec_store[base + 4];
                     ev.body.contact_angle    = dec_store[base + 6][7:5];
                  end
                  batch.push_back(ev);
               end
            end
         end
         if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
         if (emit) foreach (batch[k]) pending_events.push_back(batch[k]);
      end
   endtask

   // Present one byte on req and hold it until accepted. Bursts end with a
   // random gap; a typed golden replaces the shadow's results for that report.
   task automatic push_word(input logic [7:0] b, input logic eor, input bit typed,
                            input logic [15:0] gold_keys, input logic gold_click);
      report_event_type ev;
      req_tdata  <= b;
      req_tlast  <= eor;
      req_tvalid <= 1'b1;
      valid_held = 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      decode_report_byte(b, eor, !typed);
      if (typed) begin
         ev = '0;
         ev.body.event_kind   = EVENT_KEY;
         ev.body.key_bits     = gold_keys;
         ev.body.mouse_button = gold_click;
         ev.last_of_run       = 1'b1;
         pending_events.push_back(ev);
      end
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         valid_held = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic send_report();
      foreach (report_bytes[i]) begin
         push_word(report_bytes[i], i == report_bytes.size() - 1, 1'b0, '0, 1'b0);
      end
   endtask

   // Drop valid, then hold off until every queued result has come out and
   // any dropped report has cleared the block.
   task automatic settle_stream();
      if (valid_held) begin
         req_tvalid <= 1'b0;
         valid_held = 1'b0;
      end
      do @(posedge clock); while (pending_events.size() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_KEYS_ID:     cfg_keys_id  = value[7:0];
         CSR_TOUCH_ID:    cfg_touch_id = value[7:0];
         CSR_SKIP_PREFIX: cfg_skip     = value[0];
         CSR_MOUSE_MASK:  cfg_mask     = value;
         default: ;
      endcase
   endtask

   // Build a touch report: id, optional key prefix, hdr_len header bytes
   // starting with hdr, then finger_len finger bytes biased to the extremes.
   task automatic build_touch(input logic [7:0] hdr, input int unsigned hdr_len,
                              input int unsigned finger_len);
      int unsigned j;
      logic [7:0]  fb;
      report_bytes.delete();
      report_bytes.push_back(cfg_touch_id);
      if (cfg_skip) begin
         report_bytes.push_back(8'($urandom));
         report_bytes.push_back(8'($urandom));
      end
      if (hdr_len > 0) report_bytes.push_back(hdr);
      for (j = 1; j < hdr_len; j++) report_bytes.push_back(8'($urandom));
      for (j = 0; j < finger_len; j++) begin
         fb = 8'($urandom);
         case ($urandom_range(0, 7))
            0: fb = 8'h00;
            1: fb = 8'hff;
            default: ;
         endcase
         // Lift some fingers by zeroing their pressure byte.
         if (j % FingerBytes == 4 && $urandom_range(0, 3) == 0) fb = 8'h00;
         report_bytes.push_back(fb);
      end
   endtask

   function automatic string fmt_event(report_event_type e);
      return {$sformatf("kind=%0d keys=%h click=%0d slot=%0d down=%0d ",
                        e.body.event_kind, e.body.key_bits, e.body.mouse_button,
                        e.body.slot_index, e.body.finger_down),
              $sformatf("x=%h y=%h maj=%h min=%h prs=%h ang=%0d last=%0d",
                        e.body.pos_x, e.body.pos_y_inverted, e.body.contact_major,
                        e.body.contact_minor, e.body.contact_pressure,
                        e.body.contact_angle, e.last_of_run)};
   endfunction

   // Stall the rsp side on a randomly chosen back-pressure pattern.
   always @(posedge clock) begin
      ready_tick <= ready_tick + 1;
      if (ready_tick % 97 == 0) ready_mode <= sink_mode_type'($urandom_range(0, 3));
      case (ready_mode)
         SINK_OPEN:  rsp_tready <= 1'b1;
         SINK_COIN:  rsp_tready <= ($urandom_range(0, 1) != 0);
         SINK_COMB:  rsp_tready <= (ready_tick % 5) >= 3;
         default:    rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Check each accepted rsp word against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      report_event_type seen;
      report_event_type want;
      bit               differs;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.body.event_kind       = event_kind_type'(rsp_tuser);
         seen.body.key_bits         = rsp_tdata[15:0];
         seen.body.mouse_button     = rsp_tdata[16];
         seen.body.slot_index       = rsp_tdata[17];
         seen.body.finger_down      = rsp_tdata[18];
         seen.body.pos_x            = rsp_tdata[31:19];
         seen.body.pos_y_inverted   = rsp_tdata[45:32];
         seen.body.contact_major    = rsp_tdata[53:46];
         seen.body.contact_minor    = rsp_tdata[61:54];
         seen.body.contact_pressure = rsp_tdata[69:62];
         seen.body.contact_angle    = rsp_tdata[72:70];
         seen.last_of_run           = rsp_tlast;
         if (pending_events.size() == 0) begin
            fail_count++;
            if (fail_count <= ReportLimit)
               $display("rsp word with nothing expected: %s", fmt_event(seen));
         end else begin
            want = pending_events.pop_front();
            differs = (seen.body.event_kind       !== want.body.event_kind)
                   || (seen.body.key_bits         !== want.body.key_bits)
                   || (seen.body.mouse_button     !== want.body.mouse_button)
                   || (seen.body.slot_index       !== want.body.slot_index)
                   || (seen.body.finger_down      !== want.body.finger_down)
                   || (seen.body.pos_x            !== want.body.pos_x)
                   || (seen.body.pos_y_inverted   !== want.body.pos_y_inverted)
                   || (seen.body.contact_major    !== want.body.contact_major)
                   || (seen.body.contact_minor    !== want.body.contact_minor)
                   || (seen.body.contact_pressure !== want.body.contact_pressure)
                   || (seen.body.contact_angle    !== want.body.contact_angle)
                   || (seen.last_of_run           !== want.last_of_run);
            if (differs) begin
               fail_count++;
               if (fail_count <= ReportLimit) begin
                  $display("rsp mismatch at %0t: expected %s", $realtime, fmt_event(want));
                  $display("                      actual   %s", fmt_event(seen));
               end
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_items;
      int unsigned pick;
      int unsigned r;
      logic [26:0] row;
      logic [7:0]  kid;
      logic [7:0]  tid;
      logic        skp;
      logic [15:0] msk;
      foreach (dec_store[i]) dec_store[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table under the reset configuration.
      for (r = 0; r < DirectedRows; r++) begin
         row = directed_rows[r];
         push_word(row[26:19], row[18], row[17], row[15:0], row[16]);
      end

      for (phase = 0; phase < PhaseCount; phase++) begin
         // Reconfigure only with the stream quiet.
         settle_stream();
         kid = 8'($urandom);
         tid = 8'($urandom);
         skp = 1'($urandom);
         msk = 16'($urandom);
         case (phase)
            0: begin
               kid = 8'h00; tid = 8'hff; skp = 1'b1; msk = 16'hffff;
            end
            1: begin
               kid = 8'hff; tid = 8'h00; skp = 1'b0; msk = 16'h0000;
            end
            // Both ids equal: key result first, then the slots.
            2: tid = kid;
            default: ;
         endcase
         write_csr(CSR_KEYS_ID, {8'h00, kid});
         write_csr(CSR_TOUCH_ID, {8'h00, tid});
         write_csr(CSR_SKIP_PREFIX, {15'h0000, skp});
         write_csr(CSR_MOUSE_MASK, msk);
         csr_wen <= 1'b0;

         if (phase == 2) begin
            // Overlong report: the count saturates, touch is dropped, keys stay.
            report_bytes.delete();
            report_bytes.push_back(cfg_touch_id);
            repeat ($urandom_range(254, 260)) report_bytes.push_back(8'($urandom));
            send_report();
         end

         phase_items = 0;
         while (phase_items < PhaseWords) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               build_touch(TouchHeader, HeaderLen, FingerBytes * $urandom_range(0, MaxFingers));
            end else if (pick < 65) begin
               report_bytes.delete();
               report_bytes.push_back(cfg_keys_id);
               repeat ($urandom_range(0, 3)) report_bytes.push_back(8'($urandom));
            end else if (pick < 85) begin
               // Mostly broken touch: bad header, random length, too many fingers, short.
               case ($urandom_range(0, 3))
                  0: build_touch(8'($urandom), HeaderLen,
                                 FingerBytes * $urandom_range(0, MaxFingers));
                  1: build_touch(TouchHeader, HeaderLen, $urandom_range(1, 20));
                  2: build_touch(TouchHeader, HeaderLen, FingerBytes * (MaxFingers + 1));
                  default: build_touch(TouchHeader, $urandom_range(0, HeaderLen - 1), 0);
               endcase
            end else begin
               report_bytes.delete();
               report_bytes.push_back(8'($urandom));
               repeat ($urandom_range(0, 15)) report_bytes.push_back(8'($urandom));
            end
            send_report();
            phase_items += report_bytes.size();
            // Now and then hold the sender until the rsp side has caught up.
            if ($urandom_range(0, 11) == 0) settle_stream();
         end
      end

      settle_stream();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_events.size() == 0) begin
         $display("remote_hid_report_decoder_core regression: pass");
      end else begin
         $display("remote_hid_report_decoder_core regression: fail");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("remote_hid_report_decoder_core regression: fail");
      $finish;
   end

endmodule
